// ----- hw/rtl/asd_pkg.sv -----
package asd_pkg;

    // Stages ahead of the square root steps: the product stage and the sum stage.
    localparam int unsigned PRE_STAGES = 2;

    // Square root units: uniform scale, first row length, second row length.
    localparam int unsigned SQRT_UNITS = 3;

endpackage

// ----- hw/rtl/affine_scale_decomposition.sv -----
// Scale decomposition of the 2x2 linear part of an affine transform.
// The slave channel carries one item per matrix: the four cells as signed
// fixed-point words packed in tdata. The master channel returns one item per
// matrix: the exact determinant, the uniform scale, the x and y scales and the
// mirrored and clipped flags, packed in tdata.
// From acceptance to tvalid on the master side an item passes through one
// product stage, one sum stage, one stage per root bit for the three square
// root units running side by side, and the output register.
// One item per cycle unless the receiver stalls; root bit stages set the depth.
// Each stage holds a valid bit and loads whenever it or the stages after it
// have room, so bubbles close up and the slave side keeps taking items while
// a result waits on the master side. When the receiver stalls, the pipeline
// fills and tready falls only when every stage holds an item; nothing is lost
// or repeated.
// Reset clears all valid bits, so the pipeline comes out of reset empty and
// ready to accept an item in the first cycle.
module affine_scale_decomposition
    import asd_pkg::*;
#(
    parameter int unsigned WORD_BITS = 24,
    parameter int unsigned FRAC_BITS = 12,
    localparam int unsigned IN_BITS  = ((4 * WORD_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_RAW  = 5 * WORD_BITS,
    localparam int unsigned OUT_BITS = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // row0_col0, row0_col1, row1_col0, row1_col1, zero fill
    input  logic [IN_BITS-1:0]     i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // determinant, uniform_scale, x_scale, y_scale, mirrored, clipped, zero fill
    output logic [OUT_BITS-1:0]    o_m_axis_tdata
);
    localparam int unsigned W        = WORD_BITS;
    localparam int unsigned DW       = 2 * WORD_BITS;
    localparam int unsigned RW       = WORD_BITS + 2;
    localparam int unsigned NU       = SQRT_UNITS;

    logic signed [W-1:0] m11, m12, m21, m22;
    assign m11 = i_s_axis_tdata[W-1:0];
    assign m12 = i_s_axis_tdata[2*W-1:W];
    assign m21 = i_s_axis_tdata[3*W-1:2*W];
    assign m22 = i_s_axis_tdata[4*W-1:3*W];

    logic                 r_v0;
    logic signed [DW-1:0] r_pa, r_pb, r_q00, r_q01, r_q10, r_q11;

    logic                 r_vs   [0:W];
    logic signed [DW-1:0] r_det  [0:W];
    logic                 r_neg  [0:W];
    logic [DW-1:0]        r_x    [0:W][0:NU-1];
    logic [RW-1:0]        r_rem  [0:W][0:NU-1];
    logic [W-1:0]         r_root [0:W][0:NU-1];

    logic [DW-1:0]        n_x    [1:W][0:NU-1];
    logic [RW-1:0]        n_rem  [1:W][0:NU-1];
    logic [W-1:0]         n_root [1:W][0:NU-1];

    logic                 r_vo;
    logic [OUT_RAW-1:0]   r_out;

    logic                 rdy0;
    logic                 rdy_s  [0:W];
    logic                 rdy_o;

    logic signed [DW-1:0] n_det;
    logic [DW-1:0]        n_mag;
    logic [W-2:0]         n_uni, n_sx, n_sy;
    logic [W-1:0]         n_y;
    logic                 n_clip;
    logic [RW-1:0]        t_new, t_trial;

    always_comb begin
        rdy_o = !r_vo || i_m_axis_tready;
        rdy_s[W] = !r_vs[W] || rdy_o;
        for (int k = W - 1; k >= 0; k--) begin
            rdy_s[k] = !r_vs[k] || rdy_s[k+1];
        end
        rdy0 = !r_v0 || rdy_s[0];
    end

    assign o_s_axis_tready = rdy0;

    always_comb begin
        n_det = r_pa - r_pb;
        n_mag = n_det[DW-1] ? DW'(-n_det) : DW'(n_det);
    end

    always_comb begin
        t_new   = '0;
        t_trial = '0;
        for (int j = 1; j <= W; j++) begin
            for (int u = 0; u < NU; u++) begin
                t_new   = {r_rem[j-1][u][W-1:0], r_x[j-1][u][DW-1:DW-2]};
                t_trial = {r_root[j-1][u], 2'b01};
                n_x[j][u] = {r_x[j-1][u][DW-3:0], 2'b00};
                if (t_new >= t_trial) begin
                    n_rem[j][u]  = t_new - t_trial;
                    n_root[j][u] = {r_root[j-1][u][W-2:0], 1'b1};
                end else begin
                    n_rem[j][u]  = t_new;
                    n_root[j][u] = {r_root[j-1][u][W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        n_uni  = r_root[W][0][W-1] ? {(W-1){1'b1}} : r_root[W][0][W-2:0];
        n_sx   = r_root[W][1][W-1] ? {(W-1){1'b1}} : r_root[W][1][W-2:0];
        n_sy   = r_root[W][2][W-1] ? {(W-1){1'b1}} : r_root[W][2][W-2:0];
        n_clip = r_root[W][1][W-1] || r_root[W][2][W-1];
        n_y    = r_neg[W] ? W'(-{1'b0, n_sy}) : {1'b0, n_sy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vo <= 1'b0;
            for (int j = 0; j <= W; j++) begin
                r_vs[j] <= 1'b0;
            end
        end else begin
            if (rdy0) begin
                r_v0 <= i_s_axis_tvalid;
            end
            if (rdy_s[0]) begin
                r_vs[0] <= r_v0;
            end
            for (int j = 1; j <= W; j++) begin
                if (rdy_s[j]) begin
                    r_vs[j] <= r_vs[j-1];
                end
            end
            if (rdy_o) begin
                r_vo <= r_vs[W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_pa  <= m11 * m22;
            r_pb  <= m21 * m12;
            r_q00 <= m11 * m11;
            r_q01 <= m12 * m12;
            r_q10 <= m21 * m21;
            r_q11 <= m22 * m22;
        end
        if (rdy_s[0]) begin
            r_det[0] <= n_det;
            r_neg[0] <= n_det[DW-1];
            r_x[0][0] <= n_mag;
            r_x[0][1] <= DW'(r_q00) + DW'(r_q01);
            r_x[0][2] <= DW'(r_q10) + DW'(r_q11);
            for (int u = 0; u < NU; u++) begin
                r_rem[0][u]  <= '0;
                r_root[0][u] <= '0;
            end
        end
        for (int j = 1; j <= W; j++) begin
            if (rdy_s[j]) begin
                r_det[j] <= r_det[j-1];
                r_neg[j] <= r_neg[j-1];
                for (int u = 0; u < NU; u++) begin
                    r_x[j][u]    <= n_x[j][u];
                    r_rem[j][u]  <= n_rem[j][u];
                    r_root[j][u] <= n_root[j][u];
                end
            end
        end
        if (rdy_o) begin
            r_out <= {n_clip, r_neg[W], n_y, n_sx, n_uni, r_det[W]};
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = OUT_BITS'(r_out);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import asd_pkg::*;

    localparam int W        = 24;
    localparam int IN_BITS  = 4 * W;
    localparam int OUT_BITS = 120;
    localparam int LATENCY  = W + 3;
    localparam longint unsigned LEN_MAX = (64'd1 << (W - 1)) - 1;
    localparam logic signed [W-1:0] CELL_MAX = 24'sh7fffff;
    localparam logic signed [W-1:0] CELL_MIN = 24'sh800000;
    localparam logic signed [W-1:0] ONE      = 24'sd4096;

    typedef struct packed {
        logic [1:0]            pad;
        logic                  clipped;
        logic                  mirrored;
        logic signed [W-1:0]   y_scale;
        logic [W-2:0]          x_scale;
        logic [W-2:0]          uniform_scale;
        logic signed [2*W-1:0] determinant;
    } scale_t;

    typedef struct {
        logic signed [W-1:0] m11, m12, m21, m22;
        bit                  typed;
        scale_t              res;
    } matrix_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_BITS-1:0]  i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] o_m_axis_tdata;

    scale_t      scale_q[$];
    matrix_row_t offered_q[$];
    int          tx_idle, rx_idle;
    int          hold_cnt;
    bit          hold_req;
    int          errors, checked, accepted;
    bit          done;

    affine_scale_decomposition u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic scale_t decompose(logic signed [W-1:0] m11, logic signed [W-1:0] m12,
                                         logic signed [W-1:0] m21, logic signed [W-1:0] m22);
        scale_t          r;
        longint          a, b, c, d, det;
        longint unsigned mag, uni, sx, sy;
        a   = m11;
        b   = m12;
        c   = m21;
        d   = m22;
        det = a * d - c * b;
        mag = det < 0 ? -det : det;
        uni = isqrt(mag);
        if (uni > LEN_MAX) uni = LEN_MAX;
        sx = isqrt(longint'(a * a) + longint'(b * b));
        sy = isqrt(longint'(c * c) + longint'(d * d));
        r = '0;
        r.clipped = (sx > LEN_MAX) || (sy > LEN_MAX);
        if (sx > LEN_MAX) sx = LEN_MAX;
        if (sy > LEN_MAX) sy = LEN_MAX;
        r.determinant   = det[2*W-1:0];
        r.uniform_scale = uni[W-2:0];
        r.x_scale       = sx[W-2:0];
        r.mirrored      = det < 0;
        r.y_scale       = det < 0 ? -$signed({1'b0, sy[W-2:0]}) : $signed({1'b0, sy[W-2:0]});
        return r;
    endfunction

    function automatic logic signed [W-1:0] pick_cell();
        case ($urandom_range(0, 6))
            0: return CELL_MAX;
            1: return CELL_MIN;
            2: return '0;
            3: return $signed(W'($urandom_range(0, 32767))) - 24'sd16384;
            4: return $signed(W'($urandom_range(0, 16383))) - 24'sd8192 + ONE;
            default: return $signed(W'($urandom));
        endcase
    endfunction

    task automatic send(matrix_row_t row);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_idle) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        offered_q.push_back(row);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {row.m22, row.m21, row.m12, row.m11};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_drained();
        while (scale_q.size() != 0 || offered_q.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        matrix_row_t row;
        scale_t      got, want;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            row = offered_q.pop_front();
            scale_q.push_back(row.typed ? row.res
                                        : decompose(row.m11, row.m12, row.m21, row.m22));
            accepted++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = scale_t'({2'b00, o_m_axis_tdata});
            if (scale_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected item out: %h", o_m_axis_tdata);
            end else begin
                want = scale_q.pop_front();
                checked++;
                if (got.determinant !== want.determinant
                    || got.uniform_scale !== want.uniform_scale
                    || got.x_scale !== want.x_scale || got.y_scale !== want.y_scale
                    || got.mirrored !== want.mirrored || got.clipped !== want.clipped) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch item %0d: det %0d/%0d uni %0d/%0d x %0d/%0d y %0d/%0d m %b/%b c %b/%b",
                                 checked, want.determinant, got.determinant,
                                 want.uniform_scale, got.uniform_scale, want.x_scale,
                                 got.x_scale, want.y_scale, got.y_scale, want.mirrored,
                                 got.mirrored, want.clipped, got.clipped);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Timeout with %0d items outstanding.", scale_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        matrix_row_t table_rows[$];
        matrix_row_t row;
        scale_t      r;
        tx_idle = 15;
        rx_idle = 84;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        r = '0;
        table_rows.push_back('{'0, '0, '0, '0, 1'b1, r});
        r = '0;
        r.determinant = 48'sd16777216;
        r.uniform_scale = 23'd4096;
        r.x_scale = 23'd4096;
        r.y_scale = 24'sd4096;
        table_rows.push_back('{ONE, '0, '0, ONE, 1'b1, r});
        r.determinant = -48'sd16777216;
        r.y_scale = -24'sd4096;
        r.mirrored = 1'b1;
        table_rows.push_back('{ONE, '0, '0, -ONE, 1'b1, r});
        r = '0;
        r.x_scale = LEN_MAX[W-2:0];
        r.y_scale = $signed({1'b0, LEN_MAX[W-2:0]});
        r.clipped = 1'b1;
        table_rows.push_back('{CELL_MIN, CELL_MIN, CELL_MIN, CELL_MIN, 1'b1, r});
        table_rows.push_back('{CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX, 1'b1, r});
        r = '0;
        table_rows.push_back('{CELL_MAX, '0, '0, CELL_MAX, 1'b0, r});
        table_rows.push_back('{CELL_MIN, '0, '0, CELL_MIN, 1'b0, r});
        table_rows.push_back('{CELL_MIN, '0, '0, CELL_MAX, 1'b0, r});
        table_rows.push_back('{CELL_MAX, CELL_MIN, CELL_MAX, CELL_MAX, 1'b0, r});
        table_rows.push_back('{CELL_MAX, CELL_MAX, CELL_MIN, CELL_MAX, 1'b0, r});
        table_rows.push_back('{'0, CELL_MIN, CELL_MIN, '0, 1'b0, r});
        table_rows.push_back('{'0, ONE, ONE, '0, 1'b0, r});
        table_rows.push_back('{24'sd12288, 24'sd16384, -24'sd1, 24'sd1, 1'b0, r});
        table_rows.push_back('{-24'sd1, -24'sd1, -24'sd1, -24'sd1, 1'b0, r});
        table_rows.push_back('{24'sd1, 24'sd2, 24'sd3, 24'sd4, 1'b0, r});
        table_rows.push_back('{24'sh5a5a5a, 24'sha5a5a5, 24'sh5a5a5a, 24'sha5a5a5, 1'b0, r});
        foreach (table_rows[i]) send(table_rows[i]);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int n = 0; n < 450; n++) begin
            if (n == 150) begin
                tx_idle = 84;
                rx_idle = 15;
            end
            if (n == 300) begin
                tx_idle = 0;
                rx_idle = 0;
                hold_req = 1'b1;
            end
            if (n == 225) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            row.m11 = pick_cell();
            row.m12 = pick_cell();
            row.m21 = pick_cell();
            row.m22 = pick_cell();
            row.typed = 1'b0;
            send(row);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d matrices (%0d accepted): cell extremes, mirrored and clipped cases,",
                 checked, accepted);
        $display("random cells under sender and receiver stalls and a long output hold-off.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
